// ===== design/pfsp_pkg.sv =====
// Shared types and constants for the parallel flash sector programmer.
// Used by the controller, the datapath and the top level; depends on nothing.
package pfsp_pkg;

  // Default geometry.
  localparam int SECTOR_WORDS_DEF = 2048;
  localparam int ADDR_BITS_DEF    = 20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_EXP_MAKER   = 2'd1;
  localparam logic [1:0] CFG_EXP_DEVICE  = 2'd2;
  localparam logic [1:0] CFG_CHIP_LOG2   = 2'd3;

  // Configuration reset values.
  localparam logic [2:0] RETRY_LIMIT_RST = 3'd3;
  localparam logic [4:0] CHIP_LOG2_RST   = 5'd20;

  // Input request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Result operation codes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // Job status codes.
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_IOERR  = 2'd1;
  localparam logic [1:0] STS_UNSUPP = 2'd2;

  // Flash command words and unlock addresses.
  localparam logic [15:0] UNLOCK_A1   = 16'h5555;
  localparam logic [15:0] UNLOCK_A2   = 16'h2AAA;
  localparam logic [15:0] CMD_AA      = 16'h00AA;
  localparam logic [15:0] CMD_55      = 16'h0055;
  localparam logic [15:0] CMD_RESET   = 16'h00F0;
  localparam logic [15:0] CMD_ID      = 16'h0090;
  localparam logic [15:0] CMD_PROGRAM = 16'h00A0;
  localparam logic [15:0] CMD_ERASE   = 16'h0080;
  localparam logic [15:0] CMD_SECTOR  = 16'h0030;
  localparam logic [15:0] BLANK_WORD  = 16'hFFFF;
  localparam int          POLL_BIT    = 6;

  // Controller states; the W_ states wait for an input item.
  typedef enum logic [5:0] {
    ST_IDLE, ST_ID_AA, ST_ID_55, ST_ID_90, ST_RD0, ST_W_MAKER, ST_RD1, ST_W_DEVICE,
    ST_RST0, ST_RST1, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E_RD,
    ST_W_E_FIRST, ST_RD_ETOG, ST_W_E_TOGGLE, ST_RD_EFIN, ST_W_E_FINAL,
    ST_FAIL_F0, ST_FAIL, ST_SCAN, ST_SCAN_CHK,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P_RD,
    ST_W_P_FIRST, ST_RD_PTOG, ST_W_P_TOGGLE, ST_RD_PFIN, ST_W_P_FINAL,
    ST_VSTART, ST_W_VERIFY, ST_V_NEXT, ST_FIN
  } state_t;

  // Address source of a result.
  typedef enum logic [3:0] {
    AS_ZERO, AS_ONE, AS_U1, AS_U2, AS_BASE_U1, AS_BASE_U2, AS_JOB, AS_POLL, AS_JOBPOS
  } addr_sel_t;

  // Data source of a result.
  typedef enum logic [3:0] {
    DS_ZERO, DS_AA, DS_55, DS_ID, DS_ERASE, DS_SECTOR, DS_PROGRAM, DS_RESET, DS_EXP
  } data_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      emit;
    logic [1:0] op;
    addr_sel_t asel;
    data_sel_t dsel;
    logic      last;
    logic      load_we;
    logic      start_job;
    logic      latch_maker;
    logic      latch_device;
    logic      load_attempts;
    logic      dec_attempts;
    logic      clr_attempts;
    logic      erase_poll;
    logic      set_prev;
    logic      pos_clr;
    logic      pos_inc;
    logic      set_prog;
    logic      set_status;
    logic [1:0] status_code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic dev_ok;
    logic toggled;
    logic read_match;
    logic verify_match;
    logic blank;
    logic pos_end;
    logic attempts_gt1;
    logic erase_only;
  } dp_sts_t;

endpackage

// ===== design/pfsp_ctrl.sv =====
// Controller state machine of the flash sector programmer.
// Depends on pfsp_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module pfsp_ctrl import pfsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_stall,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   waiting;
  logic   acc;
  logic   rd_acc;

  // Items are taken only while idle or waiting for flash read data.
  always_comb begin
    unique case (state)
      ST_IDLE, ST_W_MAKER, ST_W_DEVICE, ST_W_E_FIRST, ST_W_E_TOGGLE, ST_W_E_FINAL,
      ST_W_P_FIRST, ST_W_P_TOGGLE, ST_W_P_FINAL, ST_W_VERIFY: waiting = 1'b1;
      default: waiting = 1'b0;
    endcase
  end

  assign in_stall = !waiting;
  assign acc      = in_valid && waiting;
  assign rd_acc   = acc && (req_type == REQ_READ);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && req_type == REQ_START) state_next = ST_ID_AA;
      end
      ST_ID_AA:   if (sts.out_free) state_next = ST_ID_55;
      ST_ID_55:   if (sts.out_free) state_next = ST_ID_90;
      ST_ID_90:   if (sts.out_free) state_next = ST_RD0;
      ST_RD0:     if (sts.out_free) state_next = ST_W_MAKER;
      ST_W_MAKER: if (rd_acc) state_next = ST_RD1;
      ST_RD1:     if (sts.out_free) state_next = ST_W_DEVICE;
      ST_W_DEVICE: if (rd_acc) state_next = ST_RST0;
      ST_RST0:    if (sts.out_free) state_next = ST_RST1;
      ST_RST1: begin
        if (sts.out_free) state_next = sts.dev_ok ? ST_E1 : ST_FIN;
      end
      ST_E1:      if (sts.out_free) state_next = ST_E2;
      ST_E2:      if (sts.out_free) state_next = ST_E3;
      ST_E3:      if (sts.out_free) state_next = ST_E4;
      ST_E4:      if (sts.out_free) state_next = ST_E5;
      ST_E5:      if (sts.out_free) state_next = ST_E6;
      ST_E6:      if (sts.out_free) state_next = ST_E_RD;
      ST_E_RD:    if (sts.out_free) state_next = ST_W_E_FIRST;
      ST_W_E_FIRST: if (rd_acc) state_next = ST_RD_ETOG;
      ST_RD_ETOG: if (sts.out_free) state_next = ST_W_E_TOGGLE;
      ST_W_E_TOGGLE: begin
        if (rd_acc) state_next = sts.toggled ? ST_RD_ETOG : ST_RD_EFIN;
      end
      ST_RD_EFIN: if (sts.out_free) state_next = ST_W_E_FINAL;
      ST_W_E_FINAL: begin
        if (rd_acc) begin
          if (!sts.read_match) state_next = ST_FAIL_F0;
          else if (sts.erase_only) state_next = ST_FIN;
          else state_next = ST_SCAN;
        end
      end
      ST_FAIL_F0: if (sts.out_free) state_next = ST_FAIL;
      ST_FAIL:    state_next = sts.attempts_gt1 ? ST_E1 : ST_FIN;
      ST_SCAN:    state_next = sts.pos_end ? ST_VSTART : ST_SCAN_CHK;
      ST_SCAN_CHK: state_next = sts.blank ? ST_SCAN : ST_P1;
      ST_P1:      if (sts.out_free) state_next = ST_P2;
      ST_P2:      if (sts.out_free) state_next = ST_P3;
      ST_P3:      if (sts.out_free) state_next = ST_P4;
      ST_P4:      if (sts.out_free) state_next = ST_P_RD;
      ST_P_RD:    if (sts.out_free) state_next = ST_W_P_FIRST;
      ST_W_P_FIRST: if (rd_acc) state_next = ST_RD_PTOG;
      ST_RD_PTOG: if (sts.out_free) state_next = ST_W_P_TOGGLE;
      ST_W_P_TOGGLE: begin
        if (rd_acc) state_next = sts.toggled ? ST_RD_PTOG : ST_RD_PFIN;
      end
      ST_RD_PFIN: if (sts.out_free) state_next = ST_W_P_FINAL;
      ST_W_P_FINAL: begin
        if (rd_acc) state_next = sts.read_match ? ST_SCAN : ST_FAIL_F0;
      end
      ST_VSTART:  if (sts.out_free) state_next = ST_W_VERIFY;
      ST_W_VERIFY: begin
        if (rd_acc) state_next = sts.verify_match ? ST_V_NEXT : ST_FAIL;
      end
      ST_V_NEXT: begin
        if (sts.pos_end) state_next = ST_FIN;
        else if (sts.out_free) state_next = ST_W_VERIFY;
      end
      ST_FIN:     if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    cmd.asel = AS_ZERO;
    cmd.dsel = DS_ZERO;
    cmd.op   = OP_WRITE;
    unique case (state)
      ST_IDLE: begin
        cmd.load_we   = acc && (req_type == REQ_LOAD);
        cmd.start_job = acc && (req_type == REQ_START);
      end
      ST_ID_AA: begin cmd.emit = 1'b1; cmd.asel = AS_U1; cmd.dsel = DS_AA; end
      ST_ID_55: begin cmd.emit = 1'b1; cmd.asel = AS_U2; cmd.dsel = DS_55; end
      ST_ID_90: begin cmd.emit = 1'b1; cmd.asel = AS_U1; cmd.dsel = DS_ID; end
      ST_RD0: begin cmd.emit = 1'b1; cmd.op = OP_READ; cmd.last = 1'b1; end
      ST_W_MAKER: cmd.latch_maker = rd_acc;
      ST_RD1: begin
        cmd.emit = 1'b1; cmd.op = OP_READ; cmd.asel = AS_ONE; cmd.last = 1'b1;
      end
      ST_W_DEVICE: begin
        cmd.latch_device  = rd_acc;
        cmd.load_attempts = rd_acc;
      end
      ST_RST0: begin cmd.emit = 1'b1; cmd.dsel = DS_RESET; end
      ST_RST1: begin
        cmd.emit = 1'b1; cmd.asel = AS_JOB; cmd.dsel = DS_RESET;
        cmd.set_status  = sts.out_free && !sts.dev_ok;
        cmd.status_code = STS_UNSUPP;
      end
      ST_E1: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U1; cmd.dsel = DS_AA; end
      ST_E2: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U2; cmd.dsel = DS_55; end
      ST_E3: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U1; cmd.dsel = DS_ERASE; end
      ST_E4: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U1; cmd.dsel = DS_AA; end
      ST_E5: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U2; cmd.dsel = DS_55; end
      ST_E6: begin
        cmd.emit = 1'b1; cmd.asel = AS_JOB; cmd.dsel = DS_SECTOR;
        cmd.erase_poll = sts.out_free;
      end
      ST_E_RD, ST_RD_ETOG, ST_RD_EFIN, ST_P_RD, ST_RD_PTOG, ST_RD_PFIN: begin
        cmd.emit = 1'b1; cmd.op = OP_READ; cmd.asel = AS_POLL; cmd.last = 1'b1;
      end
      ST_W_E_FIRST, ST_W_E_TOGGLE, ST_W_P_FIRST, ST_W_P_TOGGLE: cmd.set_prev = rd_acc;
      ST_W_E_FINAL: begin
        cmd.pos_clr     = rd_acc && sts.read_match && !sts.erase_only;
        cmd.set_status  = rd_acc && sts.read_match && sts.erase_only;
        cmd.status_code = STS_OK;
      end
      ST_FAIL_F0: begin cmd.emit = 1'b1; cmd.asel = AS_POLL; cmd.dsel = DS_RESET; end
      ST_FAIL: begin
        cmd.dec_attempts = sts.attempts_gt1;
        cmd.clr_attempts = !sts.attempts_gt1;
        cmd.set_status   = !sts.attempts_gt1;
        cmd.status_code  = STS_IOERR;
      end
      ST_SCAN: cmd.pos_clr = sts.pos_end;
      ST_SCAN_CHK: begin
        cmd.pos_inc  = sts.blank;
        cmd.set_prog = !sts.blank;
      end
      ST_P1: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U1; cmd.dsel = DS_AA; end
      ST_P2: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U2; cmd.dsel = DS_55; end
      ST_P3: begin cmd.emit = 1'b1; cmd.asel = AS_BASE_U1; cmd.dsel = DS_PROGRAM; end
      ST_P4: begin cmd.emit = 1'b1; cmd.asel = AS_POLL; cmd.dsel = DS_EXP; end
      ST_W_P_FINAL: cmd.pos_inc = rd_acc && sts.read_match;
      ST_VSTART: begin
        cmd.emit = 1'b1; cmd.op = OP_READ; cmd.asel = AS_JOB; cmd.last = 1'b1;
      end
      ST_W_VERIFY: cmd.pos_inc = rd_acc && sts.verify_match;
      ST_V_NEXT: begin
        cmd.emit        = !sts.pos_end;
        cmd.op          = OP_READ;
        cmd.asel        = AS_JOBPOS;
        cmd.last        = 1'b1;
        cmd.pos_clr     = sts.pos_end;
        cmd.set_status  = sts.pos_end;
        cmd.status_code = STS_OK;
      end
      ST_FIN: begin cmd.emit = 1'b1; cmd.op = OP_STATUS; cmd.last = 1'b1; end
      default: cmd.emit = 1'b0;
    endcase
  end

  // A failed attempt with budget left restarts the erase.
  a_retry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FAIL && sts.attempts_gt1) |=> (state == ST_E1))
    else $error("retry did not restart erase");

  // A delivered status result ends the job.
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && sts.out_free) |=> (state == ST_IDLE))
    else $error("job did not return to idle after status");

  // Verify never waits on a position past the sector.
  a_verify_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_VERIFY) |-> !sts.pos_end)
    else $error("verify position out of range");

endmodule

// ===== design/pfsp_dp.sv =====
// Datapath of the flash sector programmer: sector image memory, job registers,
// configuration registers and the result output register. Depends on pfsp_pkg.
module pfsp_dp import pfsp_pkg::*; #(
  parameter int SECTOR_WORDS = SECTOR_WORDS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  localparam int IW = $clog2(SECTOR_WORDS),
  localparam int AW = ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic [IW-1:0] buffer_index,
  input  logic [15:0]   word_value,
  input  logic [AW-1:0] sector_address,
  input  logic          erase_only,
  input  logic [15:0]   read_value,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    bus_op,
  output logic [AW-1:0] bus_address,
  output logic [15:0]   bus_data,
  output logic [1:0]    status,
  output logic          last
);

  localparam int PW = IW + 1;

  logic [2:0]    retry_limit;
  logic [7:0]    exp_maker;
  logic [7:0]    exp_device;
  logic [4:0]    chip_log2;
  logic [15:0]   mem [SECTOR_WORDS];
  logic [15:0]   rdata;
  logic [PW-1:0] pos;
  logic [AW-1:0] job_sector;
  logic          job_erase_only;
  logic [15:0]   prev_read;
  logic [15:0]   exp_word;
  logic [AW-1:0] poll_addr;
  logic [2:0]    attempts;
  logic [7:0]    maker_seen;
  logic          dev_ok;
  logic [1:0]    job_status;
  logic [AW-1:0] base_mask;
  logic [AW-1:0] chip_base;
  logic [AW-1:0] job_pos;
  logic [AW-1:0] addr_mux;
  logic [15:0]   data_mux;
  logic          out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RST;
      exp_maker   <= '0;
      exp_device  <= '0;
      chip_log2   <= CHIP_LOG2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[2:0];
        CFG_EXP_MAKER:   exp_maker   <= cfg_data;
        CFG_EXP_DEVICE:  exp_device  <= cfg_data;
        CFG_CHIP_LOG2:   chip_log2   <= cfg_data[4:0];
        default:         retry_limit <= retry_limit;
      endcase
    end
  end

  // Sector image memory: written by loads, read at the word position.
  always_ff @(posedge clk) begin
    if (cmd.load_we) mem[buffer_index] <= word_value;
    rdata <= mem[pos[IW-1:0]];
  end

  // Job and polling registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      job_sector     <= '0;
      job_erase_only <= 1'b0;
      prev_read      <= '0;
      exp_word       <= '0;
      poll_addr      <= '0;
      attempts       <= '0;
      maker_seen     <= '0;
      dev_ok         <= 1'b0;
      job_status     <= STS_OK;
    end else begin
      if (cmd.start_job) begin
        job_sector     <= sector_address & ~AW'(SECTOR_WORDS - 1);
        job_erase_only <= erase_only;
      end
      if (cmd.latch_maker) maker_seen <= read_value[7:0];
      if (cmd.latch_device) begin
        dev_ok <= (maker_seen == exp_maker) && (read_value[7:0] == exp_device);
      end
      if (cmd.load_attempts) attempts <= retry_limit;
      else if (cmd.dec_attempts) attempts <= attempts - 3'd1;
      else if (cmd.clr_attempts) attempts <= '0;
      if (cmd.erase_poll) begin
        poll_addr <= job_sector;
        exp_word  <= BLANK_WORD;
      end else if (cmd.set_prog) begin
        poll_addr <= job_pos;
        exp_word  <= rdata;
      end
      if (cmd.set_prev) prev_read <= read_value;
      if (cmd.pos_clr) pos <= '0;
      else if (cmd.pos_inc) pos <= pos + PW'(1);
      if (cmd.set_status) job_status <= cmd.status_code;
    end
  end

  // Chip base: job sector with the low chip_log2 bits cleared.
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      base_mask[i] = (i >= int'(chip_log2));
    end
  end

  assign chip_base = job_sector & base_mask;
  assign job_pos   = job_sector + AW'(pos[IW-1:0]);

  // Result address and data selection.
  always_comb begin
    unique case (cmd.asel)
      AS_ZERO:    addr_mux = '0;
      AS_ONE:     addr_mux = AW'(1);
      AS_U1:      addr_mux = AW'(UNLOCK_A1);
      AS_U2:      addr_mux = AW'(UNLOCK_A2);
      AS_BASE_U1: addr_mux = chip_base + AW'(UNLOCK_A1);
      AS_BASE_U2: addr_mux = chip_base + AW'(UNLOCK_A2);
      AS_JOB:     addr_mux = job_sector;
      AS_POLL:    addr_mux = poll_addr;
      AS_JOBPOS:  addr_mux = job_pos;
      default:    addr_mux = '0;
    endcase
    unique case (cmd.dsel)
      DS_ZERO:    data_mux = '0;
      DS_AA:      data_mux = CMD_AA;
      DS_55:      data_mux = CMD_55;
      DS_ID:      data_mux = CMD_ID;
      DS_ERASE:   data_mux = CMD_ERASE;
      DS_SECTOR:  data_mux = CMD_SECTOR;
      DS_PROGRAM: data_mux = CMD_PROGRAM;
      DS_RESET:   data_mux = CMD_RESET;
      DS_EXP:     data_mux = exp_word;
      default:    data_mux = '0;
    endcase
  end

  // Output register: refilled when empty or when its item is being taken.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cmd.emit) begin
      bus_op      <= cmd.op;
      bus_address <= (cmd.op == OP_STATUS) ? '0 : addr_mux;
      bus_data    <= (cmd.op == OP_WRITE) ? data_mux : '0;
      status      <= (cmd.op == OP_STATUS) ? job_status : STS_OK;
      last        <= cmd.last;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.out_free     = out_free;
    sts.dev_ok       = dev_ok;
    sts.toggled      = read_value[POLL_BIT] ^ prev_read[POLL_BIT];
    sts.read_match   = (read_value == exp_word);
    sts.verify_match = (read_value == rdata);
    sts.blank        = (rdata == BLANK_WORD);
    sts.pos_end      = pos[PW-1];
    sts.attempts_gt1 = (attempts > 3'd1);
    sts.erase_only   = job_erase_only;
  end

endmodule

// ===== design/parallel_flash_sector_programmer.sv =====
// Parallel NOR flash sector programmer: identifies the device, erases one sector,
// programs the loaded image, verifies it and reports a status, one bus cycle per
// result. A start item yields four results, and every returned read yields one to
// nine. Between a toggle-poll success and the next program sequence the controller
// walks the image memory through ST_SCAN and ST_SCAN_CHK for each word to skip
// blank words. Configuration writes are taken in any cycle (cfg_ready is always
// high). Instantiates pfsp_ctrl and pfsp_dp and imports pfsp_pkg.
module parallel_flash_sector_programmer import pfsp_pkg::*; #(
  parameter int SECTOR_WORDS = SECTOR_WORDS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  localparam int IW = $clog2(SECTOR_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [IW-1:0]        buffer_index,
  input  logic [15:0]          word_value,
  input  logic [ADDR_BITS-1:0] sector_address,
  input  logic                 erase_only,
  input  logic [15:0]          read_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           bus_op,
  output logic [ADDR_BITS-1:0] bus_address,
  output logic [15:0]          bus_data,
  output logic [1:0]           status,
  output logic                 last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencing of flash command and polling steps.
  pfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, address generation and result register.
  pfsp_dp #(
    .SECTOR_WORDS (SECTOR_WORDS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .buffer_index   (buffer_index),
    .word_value     (word_value),
    .sector_address (sector_address),
    .erase_only     (erase_only),
    .read_value     (read_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bus_op         (bus_op),
    .bus_address    (bus_address),
    .bus_data       (bus_data),
    .status         (status),
    .last           (last)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the parallel flash sector programmer: acts as the flash
// behind the bus, predicts every bus cycle and status, and compares them in order.
// Depends on pfsp_pkg and parallel_flash_sector_programmer from the design folder.
module tb_top;
  import pfsp_pkg::*;

  localparam int WORDS = 2048;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  req;
    logic [10:0] idx;
    logic [15:0] wval;
    logic [19:0] sect;
    logic        eonly;
    logic [15:0] rval;
  } req_item_t;

  typedef struct {
    logic [1:0]  op;
    logic [19:0] addr;
    logic [15:0] data;
    logic [1:0]  st;
    logic        lst;
  } bus_cycle_t;

  // Flash job phases as the predictor tracks them.
  typedef enum {
    FP_IDLE, FP_MAKER, FP_DEVICE, FP_E_FIRST, FP_E_TOGGLE, FP_E_FINAL,
    FP_P_FIRST, FP_P_TOGGLE, FP_P_FINAL, FP_VERIFY
  } job_phase_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [10:0] buffer_index = '0;
  logic [15:0] word_value = '0;
  logic [19:0] sector_address = '0;
  logic erase_only = 0;
  logic [15:0] read_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] bus_op;
  logic [19:0] bus_address;
  logic [15:0] bus_data;
  logic [1:0] status;
  logic last;

  parallel_flash_sector_programmer dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .buffer_index(buffer_index), .word_value(word_value),
    .sector_address(sector_address), .erase_only(erase_only),
    .read_value(read_value),
    .out_valid(out_valid), .out_stall(out_stall), .bus_op(bus_op),
    .bus_address(bus_address), .bus_data(bus_data), .status(status), .last(last)
  );

  always #4 clk = ~clk;

  // Predictor copy of the configuration and the job state.
  logic [2:0]  retry_limit = RETRY_LIMIT_RST;
  logic [7:0]  want_maker = '0;
  logic [7:0]  want_device = '0;
  logic [4:0]  chip_log2 = CHIP_LOG2_RST;
  job_phase_t  fphase = FP_IDLE;
  logic [15:0] image [WORDS];
  int          pos = 0;
  logic [19:0] sector_base = '0;
  logic        sector_eonly = 0;
  logic [15:0] prev_rd = '0;
  logic [15:0] want_word = '0;
  logic [19:0] poll_addr = '0;
  logic [2:0]  tries_left = '0;
  logic [7:0]  maker_rd = '0;

  bus_cycle_t step_out[$];
  bus_cycle_t bus_expect[$];
  req_item_t  pend[$];
  req_item_t  cur;

  int pushed = 0, accepted = 0, checked = 0, errors = 0, cycles = 0;
  int jobs = 0, rand_items = 0, hold_cnt = 0, mode = 0;
  int n_ok = 0, n_ioerr = 0, n_unsupp = 0;
  bit slot_full = 0, hold_go = 0;

  function void put(logic [1:0] op, logic [19:0] a, logic [15:0] d, logic [1:0] s);
    bus_cycle_t r;
    r.op = op; r.addr = a; r.data = d; r.st = s; r.lst = 0;
    step_out.push_back(r);
  endfunction

  function logic [19:0] chip_base();
    logic [19:0] m;
    m = (20'd1 << chip_log2) - 20'd1;
    return sector_base & ~m;
  endfunction

  function void job_done(logic [1:0] s);
    put(OP_STATUS, '0, '0, s);
    fphase = FP_IDLE;
  endfunction

  function void begin_erase();
    logic [19:0] b;
    b = chip_base();
    put(OP_WRITE, b + 20'(UNLOCK_A1), CMD_AA, STS_OK);
    put(OP_WRITE, b + 20'(UNLOCK_A2), CMD_55, STS_OK);
    put(OP_WRITE, b + 20'(UNLOCK_A1), CMD_ERASE, STS_OK);
    put(OP_WRITE, b + 20'(UNLOCK_A1), CMD_AA, STS_OK);
    put(OP_WRITE, b + 20'(UNLOCK_A2), CMD_55, STS_OK);
    put(OP_WRITE, sector_base, CMD_SECTOR, STS_OK);
    poll_addr = sector_base;
    want_word = BLANK_WORD;
    put(OP_READ, poll_addr, '0, STS_OK);
    fphase = FP_E_FIRST;
  endfunction

  // A failed attempt retries from the erase while attempts remain.
  function void attempt_failed();
    if (tries_left > 1) begin
      tries_left--;
      begin_erase();
    end else begin
      tries_left = 0;
      job_done(STS_IOERR);
    end
  endfunction

  // Skip blank words, then program the next one or start the verify pass.
  function void program_next();
    logic [19:0] b;
    b = chip_base();
    while (pos < WORDS && image[pos] == BLANK_WORD) pos++;
    if (pos < WORDS) begin
      put(OP_WRITE, b + 20'(UNLOCK_A1), CMD_AA, STS_OK);
      put(OP_WRITE, b + 20'(UNLOCK_A2), CMD_55, STS_OK);
      put(OP_WRITE, b + 20'(UNLOCK_A1), CMD_PROGRAM, STS_OK);
      poll_addr = sector_base + pos[19:0];
      want_word = image[pos];
      put(OP_WRITE, poll_addr, want_word, STS_OK);
      put(OP_READ, poll_addr, '0, STS_OK);
      fphase = FP_P_FIRST;
    end else begin
      pos = 0;
      put(OP_READ, sector_base, '0, STS_OK);
      fphase = FP_VERIFY;
    end
  endfunction

  function void poll_result(bit ok, bit programming);
    if (!ok) begin
      put(OP_WRITE, poll_addr, CMD_RESET, STS_OK);
      attempt_failed();
    end else if (!programming) begin
      if (sector_eonly) job_done(STS_OK);
      else begin
        pos = 0;
        program_next();
      end
    end else begin
      pos++;
      program_next();
    end
  endfunction

  // Works out the bus cycles that one accepted item causes.
  function void predict_item(req_item_t it);
    step_out.delete();
    if (fphase == FP_IDLE) begin
      if (it.req == REQ_LOAD) image[it.idx] = it.wval;
      else if (it.req == REQ_START) begin
        sector_base = it.sect & ~20'(WORDS - 1);
        sector_eonly = it.eonly;
        put(OP_WRITE, 20'(UNLOCK_A1), CMD_AA, STS_OK);
        put(OP_WRITE, 20'(UNLOCK_A2), CMD_55, STS_OK);
        put(OP_WRITE, 20'(UNLOCK_A1), CMD_ID, STS_OK);
        put(OP_READ, '0, '0, STS_OK);
        fphase = FP_MAKER;
      end
    end else if (it.req == REQ_READ) begin
      case (fphase)
        FP_MAKER: begin
          maker_rd = it.rval[7:0];
          put(OP_READ, 20'd1, '0, STS_OK);
          fphase = FP_DEVICE;
        end
        FP_DEVICE: begin
          put(OP_WRITE, '0, CMD_RESET, STS_OK);
          put(OP_WRITE, sector_base, CMD_RESET, STS_OK);
          if (maker_rd != want_maker || it.rval[7:0] != want_device) job_done(STS_UNSUPP);
          else begin
            tries_left = retry_limit;
            begin_erase();
          end
        end
        FP_E_FIRST, FP_P_FIRST: begin
          prev_rd = it.rval;
          put(OP_READ, poll_addr, '0, STS_OK);
          fphase = (fphase == FP_E_FIRST) ? FP_E_TOGGLE : FP_P_TOGGLE;
        end
        FP_E_TOGGLE, FP_P_TOGGLE: begin
          // The toggle bit settles when two successive reads agree on it.
          if (((it.rval ^ prev_rd) & 16'h0040) == 0)
            fphase = (fphase == FP_E_TOGGLE) ? FP_E_FINAL : FP_P_FINAL;
          prev_rd = it.rval;
          put(OP_READ, poll_addr, '0, STS_OK);
        end
        FP_E_FINAL: poll_result(it.rval == want_word, 0);
        FP_P_FINAL: poll_result(it.rval == want_word, 1);
        FP_VERIFY: begin
          if (pos >= WORDS || it.rval != image[pos]) attempt_failed();
          else begin
            pos++;
            if (pos >= WORDS) begin
              pos = 0;
              job_done(STS_OK);
            end else put(OP_READ, sector_base + pos[19:0], '0, STS_OK);
          end
        end
        default: fphase = FP_IDLE;
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].lst = 1;
    foreach (step_out[i]) bus_expect.push_back(step_out[i]);
  endfunction

  task report(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, bus_expect.size());
      $display("parallel_flash_sector_programmer verification failed");
      $finish;
    end
  end

  // Input acceptance feeds the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_item(cur);
      slot_full = 0;
      accepted++;
    end
  end

  // Input driver: takes the next pending item at the falling edge.
  always @(negedge clk) begin
    int gap;
    gap = (mode == 1) ? 61 : (mode == 3) ? 11 : 0;
    if (!rst && !slot_full && pend.size() > 0 && $urandom_range(99) >= gap) begin
      cur = pend.pop_front();
      slot_full = 1;
    end
    in_valid <= slot_full;
    req_type <= cur.req;
    buffer_index <= cur.idx;
    word_value <= cur.wval;
    sector_address <= cur.sect;
    erase_only <= cur.eonly;
    read_value <= cur.rval;
  end

  // Long receiver hold-off, counted here.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_cnt = 600;
      hold_go = 0;
    end else if (hold_cnt > 0) hold_cnt--;
  end

  // Output stall driver.
  always @(negedge clk) begin
    int pct;
    pct = (mode == 2) ? 61 : (mode == 3) ? 11 : 0;
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < pct);
  end

  // Output monitor.
  always @(posedge clk) begin
    bus_cycle_t e;
    if (!rst && out_valid && !out_stall) begin
      if (bus_expect.size() == 0) report($sformatf("unexpected result op %0d", bus_op));
      else begin
        e = bus_expect.pop_front();
        checked++;
        if (bus_op != e.op) report($sformatf("bus_op %0d, want %0d", bus_op, e.op));
        if (bus_address != e.addr)
          report($sformatf("bus_address %h, want %h", bus_address, e.addr));
        if (bus_data != e.data) report($sformatf("bus_data %h, want %h", bus_data, e.data));
        if (status != e.st) report($sformatf("status %0d, want %0d", status, e.st));
        if (last != e.lst) report($sformatf("last %0d, want %0d", last, e.lst));
        if (e.op == OP_STATUS) begin
          if (e.st == STS_OK) n_ok++;
          else if (e.st == STS_IOERR) n_ioerr++;
          else n_unsupp++;
        end
      end
    end
  end

  task send(req_item_t it);
    pend.push_back(it);
    pushed++;
    wait (accepted == pushed);
  endtask

  function req_item_t rand_item(logic [1:0] rq);
    req_item_t it;
    it.req = rq;
    it.idx = 11'($urandom);
    it.wval = 16'($urandom);
    it.sect = 20'($urandom);
    it.eonly = 1'($urandom);
    it.rval = 16'($urandom);
    return it;
  endfunction

  task load_word(int i, logic [15:0] v);
    req_item_t it;
    it = rand_item(REQ_LOAD);
    it.idx = 11'(i);
    it.wval = v;
    send(it);
  endtask

  task cfg_write(logic [1:0] i, logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= i;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (i)
      CFG_RETRY_LIMIT: retry_limit = v[2:0];
      CFG_EXP_MAKER: want_maker = v;
      CFG_EXP_DEVICE: want_device = v;
      default: chip_log2 = v[4:0];
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task wait_quiet();
    wait (accepted == pushed && bus_expect.size() == 0 && fphase == FP_IDLE);
    repeat (20) @(posedge clk);
  endtask

  task configure(logic [2:0] rt, logic [7:0] mk, logic [7:0] dv, logic [4:0] lg);
    wait_quiet();
    cfg_write(CFG_RETRY_LIMIT, {5'd0, rt});
    cfg_write(CFG_EXP_MAKER, mk);
    cfg_write(CFG_EXP_DEVICE, dv);
    cfg_write(CFG_CHIP_LOG2, {3'd0, lg});
  endtask

  // Plays the flash for one job: answers each read by the predicted phase.
  // fin_bad is the percent chance of a bad final poll read; bad_at is the
  // verify word that reads wrong, or -1 for a clean verify.
  task run_job(bit eo, bit id_ok, int fin_bad, int bad_at, bit counted);
    req_item_t it;
    int toggles;
    toggles = 0;
    it = rand_item(REQ_START);
    it.eonly = eo;
    send(it);
    while (fphase != FP_IDLE) begin
      if ($urandom_range(99) < 4) send(rand_item($urandom_range(1) ? 2'd3 : 2'($urandom_range(1))));
      it = rand_item(REQ_READ);
      case (fphase)
        FP_MAKER: if (id_ok) it.rval[7:0] = want_maker;
        FP_DEVICE: if (id_ok) it.rval[7:0] = want_device;
        FP_E_FIRST, FP_P_FIRST: toggles = 0;
        FP_E_TOGGLE, FP_P_TOGGLE: begin
          it.rval[6] = prev_rd[6] ^ (toggles < 5 && $urandom_range(1) == 1);
          toggles++;
        end
        FP_E_FINAL, FP_P_FINAL: begin
          it.rval = want_word;
          if ($urandom_range(99) < fin_bad) it.rval ^= 16'($urandom_range(1, 65535));
        end
        FP_VERIFY: begin
          it.rval = image[pos];
          if (pos == bad_at) it.rval ^= 16'($urandom_range(1, 65535));
        end
        default: ;
      endcase
      send(it);
      if (counted) rand_items++;
    end
    jobs++;
  endtask

  initial begin
    logic [15:0] v;
    int phase_items;
    cur = rand_item(2'd3);
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: ignored items, an unsupported ID, erase paths.
    configure(3'd2, 8'h37, 8'hC1, 5'd11);
    send(rand_item(2'd3));
    send(rand_item(REQ_READ));
    load_word(0, 16'h0000);
    load_word(WORDS - 1, 16'hFFFF);
    run_job(1, 0, 0, -1, 0);
    run_job(1, 1, 0, -1, 0);
    run_job(1, 1, 100, -1, 0);
    configure(3'd0, 8'hFF, 8'h00, 5'd20);
    run_job(1, 1, 100, -1, 0);

    // Fill the whole image, mostly blank, then one clean full job and one with a bad verify of word 0.
    for (int i = 0; i < WORDS; i++) begin
      v = BLANK_WORD;
      if (i == 0) v = 16'h0000;
      else if (i == WORDS - 1) v = 16'hFFFE;
      else if ($urandom_range(299) == 0) v = 16'($urandom);
      load_word(i, v);
    end
    configure(3'd7, 8'h00, 8'hFF, 5'd11);
    run_job(0, 1, 0, -1, 0);
    run_job(0, 1, 0, 0, 0);

    // Random phases, one per idling mode, each with its own settings.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: configure(3'd1, 8'($urandom), 8'($urandom), 5'd20);
        1: configure(3'd7, 8'($urandom), 8'($urandom), 5'($urandom_range(11, 20)));
        2: configure(3'd0, 8'hFF, 8'hFF, 5'd11);
        default: configure(3'($urandom), 8'($urandom), 8'($urandom),
                           5'($urandom_range(11, 20)));
      endcase
      mode = p;
      phase_items = rand_items;
      while (rand_items - phase_items < 65) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3))
            load_word($urandom_range(WORDS - 1),
                      ($urandom_range(99) < 70) ? BLANK_WORD : 16'($urandom));
          rand_items++;
        end
        if ($urandom_range(99) < 10) send(rand_item($urandom_range(1) ? 2'd3 : REQ_READ));
        if (p == 2 && rand_items == phase_items) hold_go = 1;
        run_job($urandom_range(99) < 40, $urandom_range(99) < 90, 8,
                ($urandom_range(99) < 3) ? -1 : $urandom_range(0, 40), 1);
      end
    end

    wait (accepted == pushed && bus_expect.size() == 0);
    repeat (50) @(posedge clk);
    if (bus_expect.size() != 0) report($sformatf("%0d results never came", bus_expect.size()));
    $display("Covered %0d jobs and %0d input items; %0d bus results checked.",
             jobs, accepted, checked);
    $display("Job outcomes: %0d ok, %0d io error, %0d unsupported device.",
             n_ok, n_ioerr, n_unsupp);
    if (errors == 0) $display("parallel_flash_sector_programmer verification clean");
    else $display("parallel_flash_sector_programmer verification failed");
    $finish;
  end
endmodule
